[rtl/sadf_pkg.sv]
// Shared types and constants for the stack allocator with deferred free.
// No dependencies; imported by the core and the checker.
`timescale 1ns / 1ps

package sadf_pkg;

   localparam int REGION_BYTES_DEF = 65536;
   localparam int META_BYTES_DEF   = 5;
   localparam int MAX_BLOCKS_DEF   = 16384;

   localparam int ADDR_W  = 16;
   localparam int COUNT_W = 17;
   localparam int CAP_RESET = 65536;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_OOM           = 3'd1,
      ST_NOT_IN_REGION = 3'd2,
      ST_DOUBLE_FREE   = 3'd3,
      ST_STACK_FULL    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC,
      S_FREE_CHK,
      S_FREE_DEC,
      S_CASC_RD,
      S_CASC_START,
      S_CASC_TEST
   } state_type;

   typedef struct packed {
      logic               operation;
      logic [COUNT_W-1:0] request_size;
      logic [ADDR_W-1:0]  block_address;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [ADDR_W-1:0]  data_address;
      logic [COUNT_W-1:0] free_bytes;
      logic [COUNT_W-1:0] used_bytes;
   } rsp_type;

endpackage

[rtl/sadf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sadf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/stack_allocator_deferred_free_core.sv]
// Stack allocator with deferred free: sequencer, cursor registers, block stack RAM
// and live flag RAM. Depends on sadf_pkg and sadf_ram.
//
//   channel | ports                              | handshake
//   --------+------------------------------------+---------------------------------
//   request | start, busy, req_data              | beat taken when start && !busy
//   result  | rsp_valid, rsp_data                | one-cycle strobe, never stalled
//   csr     | csr_valid, csr_ready, csr_data     | beat taken when valid && ready
//
// Allocate: accept, then one compare/update step. Free: accept, region check (done when
// out of region), flag test, plus a stack RAM read, flag RAM read and test for each block
// below a popped top whose flag the cascade tests, including the live one it stops on.
// After reset and after every capacity write the live flag RAM is swept, one entry
// a cycle, over all REGION_BYTES entries with busy high; csr_ready is high only when idle
// with start low. The result side has no backpressure; a result shows for one cycle.
`timescale 1ns / 1ps

module stack_allocator_deferred_free_core #(
   parameter int REGION_BYTES = sadf_pkg::REGION_BYTES_DEF,
   parameter int META_BYTES   = sadf_pkg::META_BYTES_DEF,
   parameter int MAX_BLOCKS   = sadf_pkg::MAX_BLOCKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  sadf_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output sadf_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sadf_pkg::COUNT_W-1:0]    csr_data
);

   import sadf_pkg::*;

   localparam int FW     = $clog2(REGION_BYTES);
   localparam int BW     = $clog2(MAX_BLOCKS);
   localparam int DW     = $clog2(MAX_BLOCKS + 1);
   localparam int NEED_W = COUNT_W + 1;

   function automatic logic [COUNT_W-1:0] clamp_cap(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      if (int'({15'd0, v}) > REGION_BYTES) begin
         r = COUNT_W'(REGION_BYTES);
      end else begin
         r = v;
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   logic [COUNT_W-1:0] capacity_ff, capacity_in;
   logic [COUNT_W-1:0] top_ff, top_in;
   logic [COUNT_W-1:0] free_ff, free_in;
   logic [DW-1:0]      depth_ff, depth_in;
   logic [FW-1:0]      clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [NEED_W-1:0]  need_ff;
   logic [ADDR_W-1:0]  addr_ff;

   logic               accept, csr_write;
   logic               oom, full, bad_addr, stack_empty, is_top, last_pop, clr_done;
   logic [ADDR_W-1:0]  start_addr;
   logic [DW-1:0]      depth_m1;

   logic               starts_we;
   logic [BW-1:0]      starts_wa, starts_ra;
   logic [ADDR_W-1:0]  starts_wd, starts_rd;
   logic               flag_we, flag_wd, flag_rd;
   logic [FW-1:0]      flag_wa, flag_ra;

   logic               done;
   status_type         done_status;
   logic [ADDR_W-1:0]  done_addr;
   logic               do_pop;
   logic [ADDR_W-1:0]  pop_start;

   assign accept    = start && !busy;
   assign csr_write = csr_valid && csr_ready;
   assign csr_ready = !busy && !start;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign start_addr  = addr_ff - ADDR_W'(1);
   assign depth_m1    = depth_ff - DW'(1);
   assign oom         = ({1'b0, free_ff} < need_ff);
   assign full        = (depth_ff >= DW'(MAX_BLOCKS));
   assign bad_addr    = (addr_ff == '0) || ({1'b0, addr_ff} >= capacity_ff);
   assign stack_empty = (depth_ff == '0);
   assign is_top      = (starts_rd == start_addr);
   assign last_pop    = (depth_ff == DW'(1));
   assign clr_done    = (clr_ff == FW'(REGION_BYTES - 1));

   sadf_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_BLOCKS)) u_starts (
      .clock   (clock),
      .wr_en   (starts_we),
      .wr_addr (starts_wa),
      .wr_data (starts_wd),
      .rd_addr (starts_ra),
      .rd_data (starts_rd)
   );

   sadf_ram #(.WIDTH(1), .DEPTH(REGION_BYTES)) u_flags (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_wa),
      .wr_data (flag_wd),
      .rd_addr (flag_ra),
      .rd_data (flag_rd)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               state_in = (req_data.operation == OP_FREE) ? S_FREE_CHK : S_ALLOC;
            end
         end
         S_ALLOC: state_in = S_IDLE;
         S_FREE_CHK: begin
            state_in = bad_addr ? S_IDLE : S_FREE_DEC;
         end
         S_FREE_DEC: begin
            if (!flag_rd || stack_empty || !is_top || last_pop) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_CASC_RD;
            end
         end
         S_CASC_RD:    state_in = S_CASC_START;
         S_CASC_START: state_in = S_CASC_TEST;
         S_CASC_TEST: begin
            state_in = (flag_rd || last_pop) ? S_IDLE : S_CASC_RD;
         end
         default: state_in = S_CLEAR;
      endcase
      if (csr_write) state_in = S_CLEAR;
   end

   always_comb begin
      capacity_in  = capacity_ff;
      top_in       = top_ff;
      free_in      = free_ff;
      depth_in     = depth_ff;
      clr_in       = clr_ff;
      starts_we    = 1'b0;
      starts_wa    = depth_ff[BW-1:0];
      starts_wd    = top_ff[ADDR_W-1:0];
      starts_ra    = depth_m1[BW-1:0];
      flag_we      = 1'b0;
      flag_wa      = FW'(start_addr);
      flag_wd      = 1'b0;
      flag_ra      = FW'(start_addr);
      done         = 1'b0;
      done_status  = ST_OK;
      done_addr    = '0;
      do_pop       = 1'b0;
      pop_start    = start_addr;

      case (state_ff)
         S_CLEAR: begin
            flag_we = 1'b1;
            flag_wa = clr_ff;
            flag_wd = 1'b0;
            clr_in  = clr_ff + FW'(1);
         end
         S_ALLOC: begin
            done = 1'b1;
            if (oom) begin
               done_status = ST_OOM;
            end else if (full) begin
               done_status = ST_STACK_FULL;
            end else begin
               starts_we = 1'b1;
               flag_we   = 1'b1;
               flag_wa   = FW'(top_ff);
               flag_wd   = 1'b1;
               depth_in  = depth_ff + DW'(1);
               top_in    = top_ff + need_ff[COUNT_W-1:0];
               free_in   = free_ff - need_ff[COUNT_W-1:0];
               done_addr = top_ff[ADDR_W-1:0] + ADDR_W'(1);
            end
         end
         S_FREE_CHK: begin
            if (bad_addr) begin
               done        = 1'b1;
               done_status = ST_NOT_IN_REGION;
            end
         end
         S_FREE_DEC: begin
            if (!flag_rd || stack_empty) begin
               done        = 1'b1;
               done_status = ST_DOUBLE_FREE;
            end else if (is_top) begin
               do_pop    = 1'b1;
               pop_start = start_addr;
               done      = last_pop;
            end else begin
               flag_we = 1'b1;
               flag_wa = FW'(start_addr);
               flag_wd = 1'b0;
               done    = 1'b1;
            end
         end
         S_CASC_START: begin
            flag_ra = FW'(starts_rd);
         end
         S_CASC_TEST: begin
            if (flag_rd) begin
               done = 1'b1;
            end else begin
               do_pop    = 1'b1;
               pop_start = starts_rd;
               done      = last_pop;
            end
         end
         default: begin
         end
      endcase

      if (do_pop) begin
         flag_we  = 1'b1;
         flag_wa  = FW'(pop_start);
         flag_wd  = 1'b0;
         top_in   = {1'b0, pop_start};
         free_in  = capacity_ff - {1'b0, pop_start};
         depth_in = depth_m1;
      end

      rsp_valid_in = done;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_in.status       = done_status;
         rsp_in.data_address = done_addr;
         rsp_in.free_bytes   = free_in;
         rsp_in.used_bytes   = top_in;
      end

      if (csr_write) begin
         capacity_in = clamp_cap(csr_data);
         top_in      = '0;
         free_in     = clamp_cap(csr_data);
         depth_in    = '0;
         clr_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         capacity_ff  <= clamp_cap(COUNT_W'(CAP_RESET));
         top_ff       <= '0;
         free_ff      <= clamp_cap(COUNT_W'(CAP_RESET));
         depth_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         capacity_ff  <= capacity_in;
         top_ff       <= top_in;
         free_ff      <= free_in;
         depth_ff     <= depth_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         need_ff <= NEED_W'(req_data.request_size) + NEED_W'(META_BYTES);
         addr_ff <= req_data.block_address;
      end
   end

endmodule

[rtl/sadf_checker.sv]
// Port-level checks for the stack allocator core, bound to the core module.
// Depends on sadf_pkg and stack_allocator_deferred_free_core.
`timescale 1ns / 1ps

module sadf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input sadf_pkg::rsp_type            rsp_data,
   input logic                         csr_valid,
   input logic                         csr_ready
);

   import sadf_pkg::*;

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_rsp_after_work : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without work in the previous cycle");

   a_fail_no_addr : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.data_address == '0))
      else $error("failed request returned an address");

   a_csr_sweep : assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> busy)
      else $error("capacity write did not start the flag sweep");

endmodule

bind stack_allocator_deferred_free_core sadf_checker u_sadf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);
